[src/dqs_pkg.sv]
// Shared types and codes for the bounded stack/queue store.
// No dependencies; used by dqs_cell and bounded_stack_queue_deque_top.
package dqs_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STAT_W-1:0]        stat_t;

  localparam cmd_t CMD_PUSH   = 3'd0;
  localparam cmd_t CMD_APPEND = 3'd1;
  localparam cmd_t CMD_PEEK   = 3'd2;
  localparam cmd_t CMD_POP    = 3'd3;
  localparam cmd_t CMD_SWAP   = 3'd4;

  localparam stat_t STAT_OK    = 2'd0;
  localparam stat_t STAT_EMPTY = 2'd1;
  localparam stat_t STAT_FULL  = 2'd2;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_VALUE = 2'd0;
  localparam sel_t SEL_ABOVE = 2'd1;
  localparam sel_t SEL_BELOW = 2'd2;

  typedef struct packed {
    logic en;
    sel_t sel;
  } cell_ctl_t;

endpackage

[src/dqs_cell.sv]
// One storage cell of the store: holds one word, loads from the request
// value or from a neighbor cell. Depends on dqs_pkg.
module dqs_cell (
  input  logic              clk,
  input  dqs_pkg::cell_ctl_t ctl,
  input  dqs_pkg::word_t    above,
  input  dqs_pkg::word_t    below,
  input  dqs_pkg::word_t    value,
  output dqs_pkg::word_t    q
);

  dqs_pkg::word_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      case (ctl.sel)
        dqs_pkg::SEL_VALUE: q_r <= value;
        dqs_pkg::SEL_ABOVE: q_r <= above;
        dqs_pkg::SEL_BELOW: q_r <= below;
        default:            q_r <= q_r;
      endcase
    end
  end

  assign q = q_r;

endmodule

[src/bounded_stack_queue_deque_top.sv]
// Bounded stack/queue store built as a row of shifting word cells.
// Depends on dqs_pkg and dqs_cell.
//
// Holds up to DEPTH signed 32-bit words in a row of cells, cell 0 being the
// top. Push shifts the row down and loads the top, pop shifts it up, append
// loads the cell just past the last held entry, and swap exchanges cells 0
// and 1. Every request gives one result: status, top word after the request
// (zero when empty) and entry count; the result is registered. A new request is
// taken every cycle as long as the output register is free or being drained.
// Errors (full on push/append, empty on peek/pop, fewer than two on swap)
// leave the store unchanged.
module bounded_stack_queue_deque_top #(
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [31:0]                            in_tdata,  // value[31:0]
  input  logic [2:0]                             in_tuser,  // command[2:0]
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // top_value[31:0], entry_count[32 +: $clog2(DEPTH+1)], zero pad
  output logic [((32+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata,
  output logic [1:0]                             out_tuser  // status[1:0]
);

  localparam int CW    = $clog2(DEPTH+1);
  localparam int ODW   = ((32+CW+7)/8)*8;
  localparam int PAD_W = ODW - 32 - CW;

  dqs_pkg::word_t     cell_q   [DEPTH];
  dqs_pkg::cell_ctl_t cell_ctl [DEPTH];

  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r;
  dqs_pkg::stat_t status_r, status_nxt;
  dqs_pkg::word_t top_r, top_nxt;
  dqs_pkg::cmd_t  cmd;
  dqs_pkg::word_t value;
  logic           accept, empty, full, two_plus;
  logic           do_push, do_append, do_pop, do_swap;

  assign cmd      = in_tuser;
  assign value    = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign two_plus = (count_r > CW'(1));

  assign do_push   = accept && (cmd == dqs_pkg::CMD_PUSH)   && !full;
  assign do_append = accept && (cmd == dqs_pkg::CMD_APPEND) && !full;
  assign do_pop    = accept && (cmd == dqs_pkg::CMD_POP)    && !empty;
  assign do_swap   = accept && (cmd == dqs_pkg::CMD_SWAP)   && two_plus;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      dqs_pkg::word_t above_w, below_w;

      if (gi == 0) begin : g_first
        assign above_w = value;
      end else begin : g_mid_a
        assign above_w = cell_q[gi-1];
      end
      if (gi == DEPTH-1) begin : g_last
        assign below_w = value;
      end else begin : g_mid_b
        assign below_w = cell_q[gi+1];
      end

      always_comb begin
        cell_ctl[gi].en  = 1'b0;
        cell_ctl[gi].sel = dqs_pkg::SEL_VALUE;
        if (do_push) begin
          cell_ctl[gi].en  = 1'b1;
          cell_ctl[gi].sel = (gi == 0) ? dqs_pkg::SEL_VALUE : dqs_pkg::SEL_ABOVE;
        end else if (do_pop) begin
          cell_ctl[gi].en  = 1'b1;
          cell_ctl[gi].sel = dqs_pkg::SEL_BELOW;
        end else if (do_swap) begin
          cell_ctl[gi].en  = (gi == 0) || (gi == 1);
          cell_ctl[gi].sel = (gi == 0) ? dqs_pkg::SEL_BELOW : dqs_pkg::SEL_ABOVE;
        end else if (do_append) begin
          cell_ctl[gi].en  = (count_r == CW'(gi));
          cell_ctl[gi].sel = dqs_pkg::SEL_VALUE;
        end
      end

      dqs_cell u_cell (
        .clk   (clk),
        .ctl   (cell_ctl[gi]),
        .above (above_w),
        .below (below_w),
        .value (value),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    status_nxt = dqs_pkg::STAT_OK;
    count_nxt  = count_r;
    top_nxt    = empty ? '0 : cell_q[0];
    case (cmd)
      dqs_pkg::CMD_PUSH: begin
        if (full) begin
          status_nxt = dqs_pkg::STAT_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          top_nxt   = value;
        end
      end
      dqs_pkg::CMD_APPEND: begin
        if (full) begin
          status_nxt = dqs_pkg::STAT_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          top_nxt   = empty ? value : cell_q[0];
        end
      end
      dqs_pkg::CMD_PEEK: begin
        if (empty) begin
          status_nxt = dqs_pkg::STAT_EMPTY;
        end
      end
      dqs_pkg::CMD_POP: begin
        if (empty) begin
          status_nxt = dqs_pkg::STAT_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
          top_nxt   = two_plus ? cell_q[1] : '0;
        end
      end
      dqs_pkg::CMD_SWAP: begin
        if (!two_plus) begin
          status_nxt = dqs_pkg::STAT_EMPTY;
        end else begin
          top_nxt = cell_q[1];
        end
      end
      default: begin
        status_nxt = dqs_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      top_r    <= top_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, count_r, top_r};

endmodule

[tb/tb_top.sv]
// Self-checking bench for bounded_stack_queue_deque_top: directed table, then random
// stack/queue traffic with fill-to-full and drain-to-empty runs, checked by a shadow store.
// Depends on dqs_pkg and the RTL under src.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OUT_W = ((32 + CNT_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 60;

  localparam dqs_pkg::cmd_t CMD_UNUSED5 = 3'd5;
  localparam dqs_pkg::cmd_t CMD_UNUSED6 = 3'd6;
  localparam dqs_pkg::cmd_t CMD_UNUSED7 = 3'd7;

  localparam dqs_pkg::word_t W_MIN  = 32'h8000_0000;
  localparam dqs_pkg::word_t W_MAX  = 32'h7FFF_FFFF;
  localparam dqs_pkg::word_t W_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    dqs_pkg::stat_t   status;
    dqs_pkg::word_t   top;
    logic [CNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    dqs_pkg::cmd_t  cmd;
    dqs_pkg::word_t value;
    logic           typed;
    result_t        want;
  } dir_row_t;

  localparam int N_DIR = 24;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{dqs_pkg::CMD_PEEK,   32'h0,         1'b1, '{dqs_pkg::STAT_EMPTY, 32'h0,  9'd0}},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b1, '{dqs_pkg::STAT_EMPTY, 32'h0,  9'd0}},
    '{dqs_pkg::CMD_SWAP,   32'h0,         1'b1, '{dqs_pkg::STAT_EMPTY, 32'h0,  9'd0}},
    '{CMD_UNUSED5,         32'h1234_5678, 1'b1, '{dqs_pkg::STAT_OK,    32'h0,  9'd0}},
    '{dqs_pkg::CMD_PUSH,   W_MIN,         1'b1, '{dqs_pkg::STAT_OK,    W_MIN,  9'd1}},
    '{dqs_pkg::CMD_SWAP,   32'h0,         1'b1, '{dqs_pkg::STAT_EMPTY, W_MIN,  9'd1}},
    '{dqs_pkg::CMD_PUSH,   W_MAX,         1'b1, '{dqs_pkg::STAT_OK,    W_MAX,  9'd2}},
    '{dqs_pkg::CMD_SWAP,   32'h0,         1'b1, '{dqs_pkg::STAT_OK,    W_MIN,  9'd2}},
    '{dqs_pkg::CMD_PEEK,   W_ONES,        1'b1, '{dqs_pkg::STAT_OK,    W_MIN,  9'd2}},
    '{dqs_pkg::CMD_APPEND, W_ONES,        1'b1, '{dqs_pkg::STAT_OK,    W_MIN,  9'd3}},
    '{CMD_UNUSED6,         32'h0,         1'b1, '{dqs_pkg::STAT_OK,    W_MIN,  9'd3}},
    '{CMD_UNUSED7,         W_ONES,        1'b1, '{dqs_pkg::STAT_OK,    W_MIN,  9'd3}},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b1, '{dqs_pkg::STAT_OK,    W_MAX,  9'd2}},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b1, '{dqs_pkg::STAT_OK,    W_ONES, 9'd1}},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b1, '{dqs_pkg::STAT_OK,    32'h0,  9'd0}},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b1, '{dqs_pkg::STAT_EMPTY, 32'h0,  9'd0}},
    '{dqs_pkg::CMD_APPEND, 32'h1,         1'b1, '{dqs_pkg::STAT_OK,    32'h1,  9'd1}},
    '{dqs_pkg::CMD_APPEND, 32'hA5A5_A5A5, 1'b1, '{dqs_pkg::STAT_OK,    32'h1,  9'd2}},
    '{dqs_pkg::CMD_SWAP,   32'h0,         1'b0, '0},
    '{dqs_pkg::CMD_PUSH,   32'h5A5A_5A5A, 1'b0, '0},
    '{dqs_pkg::CMD_PEEK,   32'h0,         1'b0, '0},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b0, '0},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b0, '0},
    '{dqs_pkg::CMD_POP,    32'h0,         1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;
  logic [2:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;

  dqs_pkg::word_t   shadow_words [DEPTH];
  logic [7:0]       shadow_top;
  logic [CNT_W-1:0] shadow_held;
  result_t          pending_results [$];
  int               sent_cnt = 0;
  int               fail_cnt = 0;
  bit               hold_ask = 1'b0;

  bounded_stack_queue_deque_top #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic result_t stack_apply(dqs_pkg::cmd_t cmd, dqs_pkg::word_t value);
    result_t        r;
    logic [7:0]     below;
    dqs_pkg::word_t tmp;
    r.status = dqs_pkg::STAT_OK;
    case (cmd)
      dqs_pkg::CMD_PUSH, dqs_pkg::CMD_APPEND: begin
        if (shadow_held >= DEPTH) begin
          r.status = dqs_pkg::STAT_FULL;
        end else begin
          if (cmd == dqs_pkg::CMD_PUSH) begin
            if (shadow_held > 0) shadow_top = shadow_top + 8'd1;
            shadow_words[shadow_top] = value;
          end else begin
            below = shadow_top - shadow_held[7:0];
            shadow_words[below] = value;
          end
          shadow_held = shadow_held + 1'b1;
        end
      end
      dqs_pkg::CMD_PEEK: begin
        if (shadow_held == 0) r.status = dqs_pkg::STAT_EMPTY;
      end
      dqs_pkg::CMD_POP: begin
        if (shadow_held == 0) begin
          r.status = dqs_pkg::STAT_EMPTY;
        end else begin
          shadow_held = shadow_held - 1'b1;
          if (shadow_held > 0) shadow_top = shadow_top - 8'd1;
        end
      end
      dqs_pkg::CMD_SWAP: begin
        if (shadow_held < 2) begin
          r.status = dqs_pkg::STAT_EMPTY;
        end else begin
          below = shadow_top - 8'd1;
          tmp = shadow_words[shadow_top];
          shadow_words[shadow_top] = shadow_words[below];
          shadow_words[below] = tmp;
        end
      end
      default: ;
    endcase
    r.top = (shadow_held > 0) ? shadow_words[shadow_top] : '0;
    r.count = shadow_held;
    return r;
  endfunction

  function automatic int sender_pct();
    case ((sent_cnt / 50) % 4)
      1: return 48;
      3: return 29;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct();
    case ((sent_cnt / 50) % 4)
      2: return 48;
      3: return 29;
      default: return 0;
    endcase
  endfunction

  function automatic dqs_pkg::word_t pick_value();
    case ($urandom_range(15))
      0: return W_MIN;
      1: return W_MAX;
      2: return '0;
      3: return W_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic dqs_pkg::cmd_t pick_unused();
    case ($urandom_range(2))
      0: return CMD_UNUSED5;
      1: return CMD_UNUSED6;
      default: return CMD_UNUSED7;
    endcase
  endfunction

  function automatic dqs_pkg::cmd_t pick_mix_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 30) return dqs_pkg::CMD_PUSH;
    if (r < 50) return dqs_pkg::CMD_APPEND;
    if (r < 62) return dqs_pkg::CMD_PEEK;
    if (r < 80) return dqs_pkg::CMD_POP;
    if (r < 93) return dqs_pkg::CMD_SWAP;
    return pick_unused();
  endfunction

  function automatic dqs_pkg::cmd_t pick_fill_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 45) return dqs_pkg::CMD_PUSH;
    if (r < 90) return dqs_pkg::CMD_APPEND;
    if (r < 95) return dqs_pkg::CMD_SWAP;
    return dqs_pkg::CMD_PEEK;
  endfunction

  function automatic dqs_pkg::cmd_t pick_drain_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 85) return dqs_pkg::CMD_POP;
    if (r < 93) return dqs_pkg::CMD_SWAP;
    return dqs_pkg::CMD_PEEK;
  endfunction

  task automatic send_req(dqs_pkg::cmd_t cmd, dqs_pkg::word_t value, logic typed,
                          result_t want);
    result_t pred;
    int      gap_pct;
    gap_pct = sender_pct();
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    pred = stack_apply(cmd, value);
    pending_results.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  initial begin : stimulus
    result_t none;
    none = '0;
    shadow_top = '0;
    shadow_held = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_req(DIR_ROWS[i].cmd, DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int i = 0; i < 100; i++) begin
      if (i == 50) begin
        // drain everything in flight before resuming
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_req(pick_mix_cmd(), pick_value(), 1'b0, none);
    end

    hold_ask = 1'b1;
    while (shadow_held < DEPTH) send_req(pick_fill_cmd(), pick_value(), 1'b0, none);
    repeat (4) begin
      send_req($urandom_range(1) ? dqs_pkg::CMD_PUSH : dqs_pkg::CMD_APPEND, pick_value(),
               1'b0, none);
    end
    send_req(dqs_pkg::CMD_SWAP, pick_value(), 1'b0, none);
    send_req(dqs_pkg::CMD_PEEK, pick_value(), 1'b0, none);

    while (shadow_held > 0) send_req(pick_drain_cmd(), pick_value(), 1'b0, none);
    send_req(dqs_pkg::CMD_POP, pick_value(), 1'b0, none);
    send_req(dqs_pkg::CMD_SWAP, pick_value(), 1'b0, none);
    send_req(dqs_pkg::CMD_PEEK, pick_value(), 1'b0, none);
    for (int i = 0; i < 30; i++) send_req(pick_mix_cmd(), pick_value(), 1'b0, none);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : rx_side
    int hold_left;
    int pct;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      pct = stall_pct();
      if (hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_ask = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(pct > 0 && $urandom_range(99) < pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t          want;
    logic [CNT_W-1:0] got_count;
    got_count = out_tdata[32 +: CNT_W];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d top %h count %0d",
                 $time, out_tuser, out_tdata[31:0], got_count);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          fail_cnt++;
        end
        if (out_tdata[31:0] !== want.top) begin
          $display("%0t: top_value expected %h actual %h", $time, want.top, out_tdata[31:0]);
          fail_cnt++;
        end
        if (got_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got_count);
          fail_cnt++;
        end
      end
    end
  end

endmodule
